[design/pid_positional_incremental_assert.svh]
// assertion macros for the positional and incremental pid controller
// no dependencies; included by the modules that carry assertions
`ifndef PID_POSITIONAL_INCREMENTAL_ASSERT_SVH
`define PID_POSITIONAL_INCREMENTAL_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define PPI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds during reset
`define PPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPI_ASSERT(lbl, clk, rstn, prop, msg)
`define PPI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/pidpi_pkg.sv]
// shared types and constants of the positional and incremental pid controller
// no dependencies
package pidpi_pkg;

    // fixed field widths
    localparam int DATA_WIDTH = 16;
    localparam int LIM_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_UPPER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOWER = 3'd5;

    // loop modes
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    // register reset values
    localparam logic [GAIN_W-1:0]        GAIN_P_RESET    = 24'd942;
    localparam logic [GAIN_W-1:0]        GAIN_I_RESET    = 24'd28;
    localparam logic [GAIN_W-1:0]        GAIN_D_RESET    = 24'd0;
    localparam logic signed [LIM_W-1:0]  OUT_UPPER_RESET = 16'sd4000;
    localparam logic signed [LIM_W-1:0]  OUT_LOWER_RESET = -16'sd4000;

    // input request
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] setpoint;
        logic signed [DATA_WIDTH-1:0] measured;
    } pid_sample_t;

    // result request
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         clamped;
    } pid_result_t;

endpackage

[design/pid_positional_incremental.sv]
// positional / incremental pid controller with clamped drive output
// depends on pidpi_pkg and pid_positional_incremental_assert.svh
// one input register stage, one compute stage into a result register
//
// channel   direction  handshake              payload
// sample    in         sample_valid/stall     setpoint, measured
// result    out        result_valid/stall     drive, clamped
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one request per cycle unless the result stalls; samples pass s1 then result register
// the feedback path (integral, held output, error history) closes combinationally
// through three parallel multipliers, the sum and the clamp
// rst_n clears the history, integral and held output, and loads register defaults
// a stalled result holds; the input stalls only while both stages are full and the result stalls
`include "pid_positional_incremental_assert.svh"

module pid_positional_incremental
    import pidpi_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  pid_sample_t            sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output pid_result_t            result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int EW   = DATA_WIDTH + 1;
    localparam int D1W  = DATA_WIDTH + 2;
    localparam int D2W  = DATA_WIDTH + 3;
    localparam int KW   = GAIN_W + 1;
    localparam int HW   = LIM_W + GAIN_FRAC_BITS;
    localparam int PAW  = KW + D1W;
    localparam int PBW  = KW + SUM_W;
    localparam int PCW  = KW + D2W;
    localparam int QW   = PBW + 3;

    // configuration registers
    logic                     loop_mode_reg;
    logic [GAIN_W-1:0]        gain_p_reg;
    logic [GAIN_W-1:0]        gain_i_reg;
    logic [GAIN_W-1:0]        gain_d_reg;
    logic signed [LIM_W-1:0]  out_upper_reg;
    logic signed [LIM_W-1:0]  out_lower_reg;

    // controller state
    logic signed [EW-1:0]     err_last_reg, err_last_next;
    logic signed [EW-1:0]     err_before_last_reg, err_before_last_next;
    logic signed [SUM_W-1:0]  err_sum_reg, err_sum_next;
    logic signed [HW-1:0]     out_held_reg, out_held_next;

    // pipeline registers
    logic                     s1_valid_reg, s1_valid_next;
    pid_sample_t              s1_data_reg;
    logic                     out_valid_reg, out_valid_next;
    pid_result_t              out_data_reg, out_data_next;

    logic                     advance;
    logic                     load;

    // datapath
    logic signed [EW-1:0]     err;
    logic signed [D1W-1:0]    d1;
    logic signed [D2W-1:0]    d2;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [D1W-1:0]    op_a;
    logic signed [SUM_W-1:0]  op_b;
    logic signed [D2W-1:0]    op_c;
    logic signed [KW-1:0]     kp_s, ki_s, kd_s;
    logic signed [PAW-1:0]    prod_a;
    logic signed [PBW-1:0]    prod_b;
    logic signed [PCW-1:0]    prod_c;
    logic signed [QW-1:0]     base;
    logic signed [QW-1:0]     q_raw;
    logic signed [QW-1:0]     q_upper;
    logic signed [QW-1:0]     q_lower;
    logic signed [QW-1:0]     q_clamp;
    logic                     hit;

    // handshake control
    assign advance        = s1_valid_reg & (~out_valid_reg | ~result_stall);
    assign sample_stall   = s1_valid_reg & ~advance;
    assign load           = sample_valid & ~sample_stall;
    assign s1_valid_next  = load | (s1_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & result_stall);
    assign cfg_ready      = 1'b1;
    assign result_valid   = out_valid_reg;
    assign result         = out_data_reg;

    // error terms
    assign err = EW'(s1_data_reg.setpoint) - EW'(s1_data_reg.measured);
    assign d1  = D1W'(err) - D1W'(err_last_reg);
    assign d2  = D2W'(err) - (D2W'(err_last_reg) <<< 1) + D2W'(err_before_last_reg);

    // saturating integral
    assign sum_wide = (SUM_W + 1)'(err_sum_reg) + (SUM_W + 1)'(err);
    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // operand selection shares the three multipliers between modes
    always_comb
    begin
        if (loop_mode_reg == MODE_INCREMENTAL)
        begin
            op_a = d1;
            op_b = SUM_W'(err);
            op_c = d2;
            base = QW'(out_held_reg);
        end
        else
        begin
            op_a = D1W'(err);
            op_b = sum_sat;
            op_c = D2W'(d1);
            base = '0;
        end
    end

    assign kp_s   = signed'({1'b0, gain_p_reg});
    assign ki_s   = signed'({1'b0, gain_i_reg});
    assign kd_s   = signed'({1'b0, gain_d_reg});
    assign prod_a = kp_s * op_a;
    assign prod_b = ki_s * op_b;
    assign prod_c = kd_s * op_c;
    assign q_raw  = base + QW'(prod_a) + QW'(prod_b) + QW'(prod_c);

    // clamp, upper limit first
    assign q_upper = QW'(out_upper_reg) <<< GAIN_FRAC_BITS;
    assign q_lower = QW'(out_lower_reg) <<< GAIN_FRAC_BITS;
    always_comb
    begin
        q_clamp = q_raw;
        hit     = 1'b0;
        if (q_clamp > q_upper)
        begin
            q_clamp = q_upper;
            hit     = 1'b1;
        end
        if (q_clamp < q_lower)
        begin
            q_clamp = q_lower;
            hit     = 1'b1;
        end
    end

    // next state and result
    always_comb
    begin
        err_last_next        = err_last_reg;
        err_before_last_next = err_before_last_reg;
        err_sum_next         = err_sum_reg;
        out_held_next        = out_held_reg;
        out_data_next        = out_data_reg;
        if (advance)
        begin
            err_last_next        = err;
            err_before_last_next = err_last_reg;
            out_held_next        = q_clamp[HW-1:0];
            if (loop_mode_reg == MODE_POSITIONAL)
            begin
                err_sum_next = sum_sat;
            end
            out_data_next.drive   = q_clamp[GAIN_FRAC_BITS +: DATA_WIDTH];
            out_data_next.clamped = hit;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            err_last_reg        <= '0;
            err_before_last_reg <= '0;
            err_sum_reg         <= '0;
            out_held_reg        <= '0;
        end
        else
        begin
            s1_valid_reg        <= s1_valid_next;
            out_valid_reg       <= out_valid_next;
            err_last_reg        <= err_last_next;
            err_before_last_reg <= err_before_last_next;
            err_sum_reg         <= err_sum_next;
            out_held_reg        <= out_held_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_data_reg <= sample;
        end
        out_data_reg <= out_data_next;
    end

    // configuration write decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_mode_reg <= MODE_POSITIONAL;
            gain_p_reg    <= GAIN_P_RESET;
            gain_i_reg    <= GAIN_I_RESET;
            gain_d_reg    <= GAIN_D_RESET;
            out_upper_reg <= OUT_UPPER_RESET;
            out_lower_reg <= OUT_LOWER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOOP_MODE: loop_mode_reg <= cfg_data[0];
                CFG_GAIN_P:    gain_p_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    gain_i_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    gain_d_reg    <= cfg_data[GAIN_W-1:0];
                CFG_OUT_UPPER: out_upper_reg <= cfg_data[LIM_W-1:0];
                CFG_OUT_LOWER: out_lower_reg <= cfg_data[LIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // checks
    `PPI_ASSERT(a_no_stall_when_empty, clk, rst_n, !s1_valid_reg |-> !sample_stall, "input stalled with empty stage")
    `PPI_ASSERT(a_advance_fills_result, clk, rst_n, advance |=> result_valid, "advanced request not shown")
    `PPI_ASSERT(a_history_shift, clk, rst_n, advance |=> err_before_last_reg == $past(err_last_reg), "error history not shifted")
    `PPI_ASSERT(a_sum_held_incremental, clk, rst_n, (advance && loop_mode_reg == MODE_INCREMENTAL) |=> $stable(err_sum_reg), "integral moved in incremental mode")
    `PPI_ASSERT_ALWAYS(a_cfg_always_ready, clk, cfg_ready, "configuration port not ready")

endmodule
